// ===== rtl/aesd_pkg.sv =====
package aesd_pkg;

  // geometry of the sensor array
  localparam int SensorSize = 128;
  localparam int CoordW     = $clog2(SensorSize);
  localparam int MapCells   = SensorSize * SensorSize;
  localparam int IdxW       = $clog2(MapCells);
  localparam int CntW       = IdxW + 1;
  localparam logic [IdxW-1:0]   MapMax    = IdxW'(MapCells - 1);
  localparam logic [CoordW-1:0] CoordMax  = CoordW'(SensorSize - 1);

  // data widths
  localparam int PixW   = 8;
  localparam int StampW = 32;
  localparam int LevelW = 7;
  localparam int CfgW   = 32;
  localparam int CfgIdxW = 2;

  localparam logic [StampW-1:0] WrapStep      = 32'h0000_4000;
  localparam logic [StampW-1:0] DecayReset    = 32'd10000;
  localparam logic [LevelW-1:0] LevelReset    = 7'd127;

  // address word bit positions
  localparam int AddrWrapBit  = 31;
  localparam int AddrResetBit = 30;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_DECAY_INTERVAL = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_RESPONSE_LEVEL = 2'd1;

  typedef enum logic [1:0] {
    OP_EVENT = 2'd0,
    OP_SWEEP = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_EVENT = 2'd0,
    KIND_CTRL  = 2'd1,
    KIND_READ  = 2'd2,
    KIND_DONE  = 2'd3
  } kind_t;

  typedef struct packed {
    op_t               op;
    logic [31:0]       address_word;
    logic [31:0]       time_word;
    logic [CoordW-1:0] read_col;
    logic [CoordW-1:0] read_row;
  } in_req_t;

  typedef struct packed {
    kind_t              kind;
    logic [CoordW-1:0]  event_col;
    logic [CoordW-1:0]  event_row;
    logic               on_event;
    logic signed [PixW-1:0] pixel_value;
    logic [StampW-1:0]  event_time;
  } out_rsp_t;

  typedef struct packed {
    logic [StampW-1:0] decay_interval;
    logic [LevelW-1:0] response_level;
  } cfg_t;

  // surface memory access for one cycle
  typedef struct packed {
    logic              pix_we;
    logic              stamp_we;
    logic [IdxW-1:0]   waddr;
    logic [PixW-1:0]   pix_wdata;
    logic [StampW-1:0] stamp_wdata;
    logic              re;
    logic [IdxW-1:0]   raddr;
  } mem_req_t;

  typedef struct packed {
    logic [PixW-1:0]   pix;
    logic [StampW-1:0] stamp;
  } mem_rsp_t;

endpackage

// ===== rtl/aesd_surface_mem.sv =====
module aesd_surface_mem (
  input  logic              clk,
  input  aesd_pkg::mem_req_t mem_req,
  output aesd_pkg::mem_rsp_t mem_rsp
);
  import aesd_pkg::*;

  logic [PixW-1:0]   pix_mem   [MapCells];
  logic [StampW-1:0] stamp_mem [MapCells];
  logic [PixW-1:0]   pix_rd_r;
  logic [StampW-1:0] stamp_rd_r;

  // pixel map: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_req.pix_we) begin
      pix_mem[mem_req.waddr] <= mem_req.pix_wdata;
    end
    if (mem_req.re) begin
      pix_rd_r <= pix_mem[mem_req.raddr];
    end
  end

  // time map: same ports, shared addresses
  always_ff @(posedge clk) begin
    if (mem_req.stamp_we) begin
      stamp_mem[mem_req.waddr] <= mem_req.stamp_wdata;
    end
    if (mem_req.re) begin
      stamp_rd_r <= stamp_mem[mem_req.raddr];
    end
  end

  assign mem_rsp.pix   = pix_rd_r;
  assign mem_rsp.stamp = stamp_rd_r;

endmodule

// ===== rtl/aesd_ctrl.sv =====
module aesd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  aesd_pkg::cfg_t     cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  aesd_pkg::in_req_t  in_data,
  output logic               res_valid,
  output aesd_pkg::out_rsp_t res_data,
  input  logic               res_take,
  output aesd_pkg::mem_req_t mem_req,
  input  aesd_pkg::mem_rsp_t mem_rsp
);
  import aesd_pkg::*;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_SWEEP,
    S_CLEAR
  } state_t;

  state_t            state_r;
  logic [CntW-1:0]   cnt_r;
  logic [StampW-1:0] wrap_offset_r;
  logic [StampW-1:0] last_on_time_r;
  logic [StampW-1:0] limit_r;
  logic              pend_r;
  logic [IdxW-1:0]   pend_idx_r;
  logic [CoordW-1:0] rd_col_r;
  logic [CoordW-1:0] rd_row_r;
  logic              res_valid_r;
  out_rsp_t          res_r;

  logic              in_fire;
  logic [CoordW-1:0] ev_col;
  logic [CoordW-1:0] ev_row;
  logic              ev_on;
  logic [StampW-1:0] ev_stamp;
  logic              ev_dead;
  logic              ev_store;
  logic [IdxW-1:0]   ev_idx;
  logic [PixW-1:0]   ev_pix;
  logic [PixW-1:0]   level_ext;
  out_rsp_t          ev_rsp;
  out_rsp_t          done_rsp;
  logic              res_set;

  assign in_ready  = (state_r == S_IDLE) && !res_valid_r;
  assign in_fire   = in_valid && in_ready;
  assign res_valid = res_valid_r;
  assign res_data  = res_r;

  // event decode: row is flipped, index is row-major
  assign ev_col    = in_data.address_word[14:8];
  assign ev_row    = CoordMax - in_data.address_word[7:1];
  assign ev_on     = in_data.address_word[0];
  assign ev_stamp  = in_data.time_word + wrap_offset_r;
  assign ev_dead   = (ev_col == CoordMax) && (ev_row == '0);
  assign ev_store  = !in_data.address_word[AddrWrapBit] &&
                     !in_data.address_word[AddrResetBit] && !ev_dead;
  assign ev_idx    = {ev_row, ev_col};
  assign level_ext = {1'b0, cfg.response_level};
  assign ev_pix    = ev_on ? level_ext : (~level_ext + PixW'(1));

  // result words for event records and finished sweeps or clears
  always_comb begin
    ev_rsp        = '0;
    ev_rsp.kind   = KIND_CTRL;
    done_rsp      = '0;
    done_rsp.kind = KIND_DONE;
    if (!in_data.address_word[AddrWrapBit] && !in_data.address_word[AddrResetBit]) begin
      ev_rsp.kind        = ev_dead ? KIND_CTRL : KIND_EVENT;
      ev_rsp.event_col   = ev_col;
      ev_rsp.event_row   = ev_row;
      ev_rsp.on_event    = ev_on;
      ev_rsp.pixel_value = ev_dead ? '0 : ev_pix;
      ev_rsp.event_time  = ev_stamp;
    end
  end

  // a request finishes and loads the result register
  assign res_set = (in_fire && in_data.op == OP_EVENT) || (state_r == S_READ) ||
                   (state_r == S_SWEEP && cnt_r[IdxW]) ||
                   (state_r == S_CLEAR && cnt_r[IdxW-1:0] == MapMax);

  // memory port steering
  always_comb begin
    mem_req = '0;
    case (state_r)
      S_INIT: begin
        mem_req.pix_we   = 1'b1;
        mem_req.stamp_we = 1'b1;
        mem_req.waddr    = cnt_r[IdxW-1:0];
      end
      S_IDLE: begin
        if (in_fire && in_data.op == OP_EVENT && ev_store) begin
          mem_req.pix_we      = 1'b1;
          mem_req.stamp_we    = ev_on;
          mem_req.waddr       = ev_idx;
          mem_req.pix_wdata   = ev_pix;
          mem_req.stamp_wdata = ev_stamp;
        end else if (in_fire && in_data.op == OP_READ) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = {in_data.read_row, in_data.read_col};
        end
      end
      S_SWEEP: begin
        // read cell n while deciding on cell n-1
        mem_req.re     = !cnt_r[IdxW];
        mem_req.raddr  = cnt_r[IdxW-1:0];
        mem_req.pix_we = pend_r && (mem_rsp.stamp < limit_r);
        mem_req.waddr  = pend_idx_r;
      end
      S_CLEAR: begin
        mem_req.pix_we = 1'b1;
        mem_req.waddr  = cnt_r[IdxW-1:0];
      end
      default: begin
        mem_req = '0;
      end
    endcase
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_INIT;
      cnt_r          <= '0;
      wrap_offset_r  <= '0;
      last_on_time_r <= '0;
      pend_r         <= 1'b0;
      res_valid_r    <= 1'b0;
    end else begin
      if (res_set) begin
        res_valid_r <= 1'b1;
      end else if (res_take) begin
        res_valid_r <= 1'b0;
      end
      case (state_r)
        S_INIT: begin
          if (cnt_r[IdxW-1:0] == MapMax) begin
            cnt_r   <= '0;
            state_r <= S_IDLE;
          end else begin
            cnt_r <= cnt_r + CntW'(1);
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            case (in_data.op)
              OP_EVENT: begin
                res_r <= ev_rsp;
                if (in_data.address_word[AddrWrapBit]) begin
                  wrap_offset_r <= wrap_offset_r + WrapStep;
                end else if (in_data.address_word[AddrResetBit]) begin
                  wrap_offset_r <= '0;
                end
                if (ev_store && ev_on) begin
                  last_on_time_r <= ev_stamp;
                end
              end
              OP_SWEEP: begin
                cnt_r   <= '0;
                limit_r <= last_on_time_r - cfg.decay_interval;
                if (last_on_time_r < cfg.decay_interval) begin
                  state_r <= S_CLEAR;
                end else begin
                  state_r <= S_SWEEP;
                end
              end
              OP_READ: begin
                rd_col_r <= in_data.read_col;
                rd_row_r <= in_data.read_row;
                state_r  <= S_READ;
              end
              OP_CLEAR: begin
                cnt_r   <= '0;
                state_r <= S_CLEAR;
              end
              default: begin
                state_r <= S_IDLE;
              end
            endcase
          end
        end
        S_READ: begin
          res_r.kind        <= KIND_READ;
          res_r.event_col   <= rd_col_r;
          res_r.event_row   <= rd_row_r;
          res_r.on_event    <= 1'b0;
          res_r.pixel_value <= mem_rsp.pix;
          res_r.event_time  <= mem_rsp.stamp;
          state_r           <= S_IDLE;
        end
        S_SWEEP: begin
          pend_r     <= !cnt_r[IdxW];
          pend_idx_r <= cnt_r[IdxW-1:0];
          if (cnt_r[IdxW]) begin
            cnt_r   <= '0;
            res_r   <= done_rsp;
            state_r <= S_IDLE;
          end else begin
            cnt_r <= cnt_r + CntW'(1);
          end
        end
        S_CLEAR: begin
          if (cnt_r[IdxW-1:0] == MapMax) begin
            cnt_r   <= '0;
            res_r   <= done_rsp;
            state_r <= S_IDLE;
          end else begin
            cnt_r <= cnt_r + CntW'(1);
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // sweep never reads and writes the same cell in one cycle
  a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_req.pix_we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
    else $error("surface read and write hit the same cell");

  // a read finishes only into an empty result register
  a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> !res_valid_r)
    else $error("read result would overwrite a pending result");

  // an event record always yields a result on the next cycle
  a_event_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.op == OP_EVENT) |=> res_valid_r)
    else $error("event request gave no result");

  // the last sweep compare is still pending when the read side runs out
  a_sweep_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP && cnt_r[IdxW]) |-> pend_r)
    else $error("sweep lost its final cell");

endmodule

// ===== rtl/aer_event_surface_decoder_core.sv =====
// Channel   Direction  Handshake            Payload
// in_       request    in_valid/in_ready    aesd_pkg::in_req_t (op, address, time, read pixel)
// out_      result     out_valid/out_ready  aesd_pkg::out_rsp_t (kind, pixel, value, time)
// cfg_      write      cfg_we               cfg_index selects register, cfg_wdata value
//
// Event record: memory written on the accept edge; in_ready is low while the result register is full.
// Read pixel: adds the S_READ state for the registered read of the surface memory.
// Clear, or sweep with last ON time below the interval: every pixel cleared, one cell a cycle.
// Sweep: each cell's compare-and-clear write comes in the cycle after its read, beside the next read.
// After reset the memory is zeroed cell by cell with in_ready low.
// With out_ready low one result waits at the output, one more in the result register, then input stalls.
module aer_event_surface_decoder_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  aesd_pkg::in_req_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output aesd_pkg::out_rsp_t          out_data,
  input  logic                        cfg_we,
  input  logic [aesd_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [aesd_pkg::CfgW-1:0]   cfg_wdata
);
  import aesd_pkg::*;

  cfg_t     cfg_r;
  logic     res_valid;
  out_rsp_t res_data;
  logic     res_take;
  logic     out_valid_r;
  out_rsp_t out_r;
  mem_req_t mem_req;
  mem_rsp_t mem_rsp;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.decay_interval <= DecayReset;
      cfg_r.response_level <= LevelReset;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DECAY_INTERVAL: cfg_r.decay_interval <= cfg_wdata[StampW-1:0];
        CFG_RESPONSE_LEVEL: cfg_r.response_level <= cfg_wdata[LevelW-1:0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  aesd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_data  (res_data),
    .res_take  (res_take),
    .mem_req   (mem_req),
    .mem_rsp   (mem_rsp)
  );

  aesd_surface_mem u_mem (
    .clk     (clk),
    .mem_req (mem_req),
    .mem_rsp (mem_rsp)
  );

  // output register, refilled from the result register when free
  assign res_take = res_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
